// File: rtl/gcd_lcm_euclid_unit_assert.svh
// Assertion macros for the checker file gle_chk.sv.
`ifndef GCD_LCM_EUCLID_UNIT_ASSERT_SVH
`define GCD_LCM_EUCLID_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define GLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gle: assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define GLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gle: assertion failed");

`endif

// File: rtl/gle_pkg.sv
package gle_pkg;

    localparam int OPERAND_WIDTH = 31;
    localparam int LCM_WIDTH     = 2 * OPERAND_WIDTH;

    typedef logic [OPERAND_WIDTH-1:0] t_operand;
    typedef logic [LCM_WIDTH-1:0]     t_lcm;

    typedef struct packed {
        t_operand operand_a;
        t_operand operand_b;
    } t_gle_in;

    typedef struct packed {
        t_operand gcd_value;
        t_lcm     lcm_value;
        logic     input_error;
    } t_gle_out;

    // Sequencer to divider
    typedef struct packed {
        logic     start;
        t_operand dividend;
        t_operand divisor;
    } t_div_req;

    // Divider to sequencer
    typedef struct packed {
        logic     done;
        t_operand quotient;
        t_operand remainder;
    } t_div_rsp;

endpackage

// File: rtl/gle_div.sv
module gle_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gle_pkg::t_div_req i_req,
    output gle_pkg::t_div_rsp o_rsp
);

    localparam int W    = gle_pkg::OPERAND_WIDTH;
    localparam int CntW = $clog2(W);

    logic            r_active;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [W-1:0]    r_rem;
    logic [W-1:0]    r_quo;
    logic [W-1:0]    r_dvs;

    logic [W:0]      shifted;
    logic [W:0]      trial;
    logic            fits;

    // Restoring step: bring down the next dividend bit, subtract if it fits
    assign shifted = {r_rem, r_quo[W-1]};
    assign trial   = shifted - {1'b0, r_dvs};
    assign fits    = (shifted >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
                r_rem    <= '0;
                r_quo    <= i_req.dividend;
                r_dvs    <= i_req.divisor;
            end else if (r_active) begin
                r_rem <= fits ? trial[W-1:0] : shifted[W-1:0];
                r_quo <= {r_quo[W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(W - 1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// File: rtl/gcd_lcm_euclid_unit.sv
// Channel  | Direction | Handshake                     | Payload
// command  | in        | start high while busy low     | i_operands (gle_pkg::t_gle_in)
// result   | out       | o_valid, one cycle, no stall  | o_result (gle_pkg::t_gle_out)
//
// A zero operand gives its error result in the cycle after the transfer.
// Otherwise each Euclid remainder step (at most about 45 at 31 bits) and the final a / gcd
// take one division each on the one-bit-per-cycle restoring divider that they share.
// The LCM product is formed in the cycle the last quotient appears.
// Reset is synchronous and active low; it clears the sequencer and the strobe.
// The result is never held back: o_valid stands for exactly one cycle.
module gcd_lcm_euclid_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  gle_pkg::t_gle_in  i_operands,
    output logic              o_valid,
    output gle_pkg::t_gle_out o_result
);

    localparam int LcmW = gle_pkg::LCM_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GCD,
        ST_LCM
    } t_state;

    t_state            r_state;
    logic              r_valid;
    gle_pkg::t_gle_out r_res;
    gle_pkg::t_operand r_a;
    gle_pkg::t_operand r_b;
    gle_pkg::t_operand r_y;

    gle_pkg::t_div_req div_req;
    gle_pkg::t_div_rsp div_rsp;
    logic              zero_in;

    assign zero_in = (i_operands.operand_a == '0) || (i_operands.operand_b == '0);

    gle_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        div_req = '0;
        case (r_state)
            ST_IDLE: begin
                if (start && !zero_in) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = i_operands.operand_a;
                    div_req.divisor  = i_operands.operand_b;
                end
            end
            ST_GCD: begin
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    if (div_rsp.remainder == '0) begin
                        // gcd found: divide the first operand by it
                        div_req.dividend = r_a;
                        div_req.divisor  = r_y;
                    end else begin
                        div_req.dividend = r_y;
                        div_req.divisor  = div_rsp.remainder;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        if (zero_in) begin
                            r_valid <= 1'b1;
                            r_res   <= '{gcd_value: '0, lcm_value: '0, input_error: 1'b1};
                        end else begin
                            r_a     <= i_operands.operand_a;
                            r_b     <= i_operands.operand_b;
                            r_y     <= i_operands.operand_b;
                            r_state <= ST_GCD;
                        end
                    end
                end
                ST_GCD: begin
                    if (div_rsp.done) begin
                        if (div_rsp.remainder == '0) begin
                            r_state <= ST_LCM;
                        end else begin
                            r_y <= div_rsp.remainder;
                        end
                    end
                end
                ST_LCM: begin
                    if (div_rsp.done) begin
                        r_valid           <= 1'b1;
                        r_res.gcd_value   <= r_y;
                        r_res.lcm_value   <= LcmW'(div_rsp.quotient) * LcmW'(r_b);
                        r_res.input_error <= 1'b0;
                        r_state           <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

// File: rtl/gle_chk.sv
`include "gcd_lcm_euclid_unit_assert.svh"

module gle_chk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  gle_pkg::t_gle_in  i_operands,
    input  logic              o_valid,
    input  gle_pkg::t_gle_out o_result
);

    logic xfer;
    logic zero_in;

    assign xfer    = start && !busy;
    assign zero_in = (i_operands.operand_a == '0) || (i_operands.operand_b == '0);

    // Zero operand: error result right after the transfer
    `GLE_ASSERT_NEXT(a_zero_err, xfer && zero_in, o_valid && o_result.input_error)
    // Valid operands keep the unit busy
    `GLE_ASSERT_NEXT(a_busy_after, xfer && !zero_in, busy && !o_valid)
    // Result appears as the unit goes idle
    `GLE_ASSERT_NOW(a_idle_result, o_valid, !busy)
    // Good results carry a nonzero gcd and lcm; errors carry zeros
    `GLE_ASSERT_NOW(a_result_form, o_valid,
        (!o_result.input_error && o_result.gcd_value != '0 && o_result.lcm_value != '0) ||
        (o_result.input_error && o_result.gcd_value == '0 && o_result.lcm_value == '0))

endmodule

bind gcd_lcm_euclid_unit gle_chk u_gle_chk (.*);
